### hdl/gpke_pkg.sv
`timescale 1ns / 1ps

package gpke_pkg;

  localparam int NUM_BUTTONS = 12;
  localparam int NUM_DIRS    = 4;
  localparam int NUM_EVENTS  = NUM_BUTTONS + NUM_DIRS;

  localparam logic [14:0] DEADZONE_RESET = 15'd8000;

  localparam logic KEY_PRESS   = 1'b0;
  localparam logic KEY_RELEASE = 1'b1;

  typedef struct packed {
    logic [15:0]        pad_buttons;
    logic signed [15:0] stick_x;
    logic signed [15:0] stick_y;
  } in_t;

  typedef struct packed {
    logic       key_action;
    logic [6:0] key_code;
    logic       last_event;
  } out_t;

  // One sample's worth of work: which sources changed and their old level.
  typedef struct packed {
    logic [NUM_EVENTS-1:0] changed;
    logic [NUM_EVENTS-1:0] was;
  } job_t;

  // Bit of the button mask that feeds mapped button slot idx.
  function automatic logic [3:0] button_pos(input logic [3:0] idx);
    logic [3:0] pos;
    case (idx)
      4'd0:    pos = 4'd12;
      4'd1:    pos = 4'd13;
      4'd2:    pos = 4'd14;
      4'd3:    pos = 4'd15;
      4'd4:    pos = 4'd0;
      4'd5:    pos = 4'd1;
      4'd6:    pos = 4'd2;
      4'd7:    pos = 4'd3;
      4'd8:    pos = 4'd4;
      4'd9:    pos = 4'd5;
      4'd10:   pos = 4'd8;
      4'd11:   pos = 4'd9;
      default: pos = 4'd0;
    endcase
    return pos;
  endfunction

  // Keycode of event slot idx: twelve buttons, then four stick directions.
  function automatic logic [6:0] key_code_of(input logic [3:0] idx);
    logic [6:0] code;
    case (idx)
      4'd0:    code = 7'd19;
      4'd1:    code = 7'd20;
      4'd2:    code = 7'd21;
      4'd3:    code = 7'd22;
      4'd4:    code = 7'd96;
      4'd5:    code = 7'd97;
      4'd6:    code = 7'd99;
      4'd7:    code = 7'd100;
      4'd8:    code = 7'd102;
      4'd9:    code = 7'd103;
      4'd10:   code = 7'd109;
      4'd11:   code = 7'd108;
      4'd12:   code = 7'd19;
      4'd13:   code = 7'd20;
      4'd14:   code = 7'd21;
      4'd15:   code = 7'd22;
      default: code = 7'd19;
    endcase
    return code;
  endfunction

endpackage

### hdl/gamepad_to_key_event_encoder.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake           Payload
// in        input      in_valid/in_stall   gpke_pkg::in_t  (button mask, stick x/y)
// out       output     out_valid/out_stall gpke_pkg::out_t (action, keycode, last)
// cfg       input      cfg_valid/cfg_ready 15-bit stick deadzone
//
// A sample transfers whenever the job queue has room. Events leave one per
// cycle while the output is not stalled, and the next job loads on the edge of
// the last event of the job before; a job holds 16 changes at most.
// Reset (rst, synchronous) clears the held button and stick state, empties
// the queue and restores the deadzone to 8000. A stall on the output holds the
// event register; the queue then fills and stalls the input on its own.

module gamepad_to_key_event_encoder #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  gpke_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output gpke_pkg::out_t out_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [14:0]    cfg_data
);

  logic [14:0]    stick_deadzone;
  logic           q_push;
  logic           q_full;
  logic           q_pop;
  logic           q_not_empty;
  gpke_pkg::job_t push_job;
  gpke_pkg::job_t head_job;

  // The register takes a transfer in every cycle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      stick_deadzone <= gpke_pkg::DEADZONE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      stick_deadzone <= cfg_data;
    end
  end

  // Front: classify the sample against the held state, queue the changes.
  gpke_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .deadzone (stick_deadzone),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (push_job)
  );

  gpke_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_job  (push_job),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_job  (head_job)
  );

  // Back: walk the change vector lowest slot first, one event per transfer.
  gpke_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_job       (head_job),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule

### hdl/gpke_front.sv
`timescale 1ns / 1ps

module gpke_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  gpke_pkg::in_t       in_data,
  input  logic [14:0]         deadzone,
  input  logic                q_full,
  output logic                q_push,
  output gpke_pkg::job_t      q_job
);

  logic [15:0] prev_buttons;
  logic [3:0]  prev_stick_dirs;
  logic [3:0]  dirs;
  logic [gpke_pkg::NUM_BUTTONS-1:0] btn_now;
  logic [gpke_pkg::NUM_BUTTONS-1:0] btn_was;
  logic signed [16:0] xs, ys, dzs;
  logic accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    xs  = {in_data.stick_x[15], in_data.stick_x};
    ys  = {in_data.stick_y[15], in_data.stick_y};
    dzs = $signed({2'b00, deadzone});
    dirs[0] = ys < -dzs;
    dirs[1] = ys > dzs;
    dirs[2] = xs < -dzs;
    dirs[3] = xs > dzs;
  end

  always_comb begin
    for (int i = 0; i < gpke_pkg::NUM_BUTTONS; i++) begin
      btn_now[i] = in_data.pad_buttons[gpke_pkg::button_pos(4'(i))];
      btn_was[i] = prev_buttons[gpke_pkg::button_pos(4'(i))];
    end
  end

  assign q_job.was     = {prev_stick_dirs, btn_was};
  assign q_job.changed = {prev_stick_dirs ^ dirs, btn_was ^ btn_now};
  // Drop samples that change nothing; they still update the state.
  assign q_push        = accept && (q_job.changed != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_buttons    <= '0;
      prev_stick_dirs <= '0;
    end else if (accept) begin
      prev_buttons    <= in_data.pad_buttons;
      prev_stick_dirs <= dirs;
    end
  end

endmodule

### hdl/gpke_queue.sv
`timescale 1ns / 1ps

module gpke_queue #(
  parameter int DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  gpke_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output gpke_pkg::job_t head_job
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  gpke_pkg::job_t slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic do_push, do_pop;

  assign full      = count == CW'(DEPTH);
  assign not_empty = count != '0;
  assign head_job  = slots[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### hdl/gpke_back.sv
`timescale 1ns / 1ps

module gpke_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_not_empty,
  input  gpke_pkg::job_t q_job,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_stall,
  output gpke_pkg::out_t out_data
);

  logic                            busy;
  logic [gpke_pkg::NUM_EVENTS-1:0] remaining;
  logic [gpke_pkg::NUM_EVENTS-1:0] was;
  logic [gpke_pkg::NUM_EVENTS-1:0] lowest;
  logic [gpke_pkg::NUM_EVENTS-1:0] rest;
  logic [3:0]                      idx;
  logic                            out_free;
  logic                            emit;

  assign out_free = !out_valid || !out_stall;
  assign emit     = busy && out_free;
  // Load the next job when idle, or on the edge that sends the last event of this one.
  assign q_pop    = q_not_empty && (!busy || (emit && rest == '0));

  always_comb begin
    lowest = remaining & (~remaining + 1'b1);
    rest   = remaining & ~lowest;
    idx    = '0;
    for (int i = 0; i < gpke_pkg::NUM_EVENTS; i++) begin
      if (lowest[i]) begin
        idx = 4'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      remaining <= q_job.changed;
      was       <= q_job.was;
    end else if (emit) begin
      remaining <= rest;
    end
    if (emit) begin
      out_data.key_action <= was[idx] ? gpke_pkg::KEY_RELEASE : gpke_pkg::KEY_PRESS;
      out_data.key_code   <= gpke_pkg::key_code_of(idx);
      out_data.last_event <= rest == '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        busy <= 1'b1;
      end else if (emit && rest == '0) begin
        busy <= 1'b0;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
